// ===== src/banked_extended_memory_port_defines.svh =====
// Assertion macros shared by the checker of the banked extended-memory port.
// No dependencies; the including module supplies aclk and aresetn.
`ifndef BANKED_EXTENDED_MEMORY_PORT_DEFINES_SVH
`define BANKED_EXTENDED_MEMORY_PORT_DEFINES_SVH

// same-cycle implication
`define BEMP_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define BEMP_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== src/bemp_pkg.sv =====
// Types and constants of the banked extended-memory port.
// No dependencies; used by every module of the block but bemp_mem.
package bemp_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_TAKE  = 2'd2;

    localparam logic [1:0] LANE_ADDR_LO  = 2'd0;
    localparam logic [1:0] LANE_ADDR_MID = 2'd1;
    localparam logic [1:0] LANE_ADDR_HI  = 2'd2;
    localparam logic [1:0] LANE_DATA     = 2'd3;

    localparam int unsigned CAP_W       = 17;
    localparam logic [CAP_W-1:0] CAP_RESET = 17'd65536;
    localparam int unsigned ADDR_W      = 24;
    localparam logic [7:0]  IDLE_BYTE   = 8'hFF;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] port_offset;
        logic [7:0] write_data;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] dirty_mask;
    } out_beat_t;

    typedef struct packed {
        logic       use_mem;
        logic [3:0] dirty_mask;
    } pend_info_t;

endpackage

// ===== src/bemp_mem.sv =====
// Byte-wide single-port board memory with a registered read.
// Depends on nothing.
module bemp_mem #(
    parameter int unsigned DEPTH = 262144,
    parameter int unsigned AW    = 18
) (
    input  logic          aclk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);
    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/bemp_ctrl.sv =====
// Port decode: per-board address registers, dirty bits, capacity register,
// memory request generation. Depends on bemp_pkg.
module bemp_ctrl #(
    parameter int unsigned BOARDS        = 4,
    parameter int unsigned MEM_ADDR_BITS = 16,
    parameter int unsigned MEM_AW        = 18
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    fire,
    input  bemp_pkg::in_beat_t      beat,
    input  logic                    cfg_valid,
    input  logic [16:0]             cfg_wdata,
    output logic                    mem_we,
    output logic                    mem_re,
    output logic [MEM_AW-1:0]       mem_addr,
    output logic [7:0]              mem_wdata,
    output bemp_pkg::pend_info_t    info
);
    import bemp_pkg::*;

    localparam int unsigned BW = (BOARDS > 1) ? $clog2(BOARDS) : 1;

    logic [ADDR_W-1:0] addr_reg  [BOARDS];
    logic [ADDR_W-1:0] addr_next [BOARDS];
    logic [BOARDS-1:0] dirty_reg, dirty_next;
    logic [CAP_W-1:0]  cap_reg,   cap_next;

    logic [1:0]        lane;
    logic              board_ok;
    logic [BW-1:0]     board;
    logic [ADDR_W-1:0] cur;
    logic [ADDR_W-1:0] cur_inc;
    logic              addr_ok;
    logic [BOARDS+3:0] dirty_ext;

    assign lane     = beat.port_offset[1:0];
    assign board_ok = {2'b00, beat.port_offset[7:2]} < 8'(BOARDS);
    assign board    = BW'(beat.port_offset[7:2]);
    assign cur      = board_ok ? addr_reg[board] : '0;
    assign cur_inc  = cur + 24'd1;
    assign addr_ok  = (cur < {{(ADDR_W-CAP_W){1'b0}}, cap_reg})
                      && ((cur >> MEM_ADDR_BITS) == '0);
    assign dirty_ext = {4'b0000, dirty_reg};

    always_comb begin
        addr_next = addr_reg;
        dirty_next = dirty_reg;
        cap_next  = cfg_valid ? cfg_wdata : cap_reg;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        info.use_mem    = 1'b0;
        info.dirty_mask = 4'd0;
        if (fire) begin
            unique case (beat.operation)
                OP_TAKE: begin
                    info.dirty_mask = dirty_ext[3:0];
                    dirty_next = '0;
                end
                OP_WRITE: begin
                    if (board_ok) begin
                        unique case (lane)
                            LANE_ADDR_LO:  addr_next[board] = {cur[23:8], beat.write_data};
                            LANE_ADDR_MID: addr_next[board] = {cur[23:16], beat.write_data,
                                                               cur[7:0]};
                            LANE_ADDR_HI:  addr_next[board] = {beat.write_data, cur[15:0]};
                            default: begin
                                mem_we = addr_ok;
                                dirty_next[board] = 1'b1;
                                addr_next[board] = cur_inc;
                            end
                        endcase
                    end
                end
                OP_READ: begin
                    if (board_ok && lane == LANE_DATA) begin
                        mem_re = addr_ok;
                        info.use_mem = addr_ok;
                        addr_next[board] = cur_inc;
                    end
                end
                default: ;
            endcase
        end
    end

    assign mem_addr  = MEM_AW'({board, cur[MEM_ADDR_BITS-1:0]});
    assign mem_wdata = beat.write_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BOARDS; i++) begin
                addr_reg[i] <= '0;
            end
            dirty_reg <= '0;
            cap_reg   <= CAP_RESET;
        end else begin
            addr_reg  <= addr_next;
            dirty_reg <= dirty_next;
            cap_reg   <= cap_next;
        end
    end

endmodule

// ===== src/banked_extended_memory_port.sv =====
// Banked extended-memory port, top level. Depends on bemp_pkg, bemp_ctrl
// and bemp_mem.
//
// Use: each input beat (s_valid/s_ready, s_data) is one I/O port access:
// an address-lane write, a data-lane read or write, or a take of the dirty
// mask. Every input beat gives exactly one result beat on m_valid/m_ready,
// m_data, in order. Capacity is written over cfg_valid/cfg_ready/cfg_wdata,
// which is always ready; write it only while no beat is in flight.
// The result reaches m_valid after decode and memory access, then the
// memory's registered read, then the output register.
// Throughput: one beat per cycle while results are taken, set by the
// single-port board memory that serves one access per cycle.
// A stalled result holds in the output register; one more beat may be
// taken behind it, after which s_ready drops until m_ready returns.
// Reset clears the address registers, the dirty bits and the pipeline and
// restores full capacity; memory contents are undefined until written.
module banked_extended_memory_port #(
    parameter int unsigned BOARDS        = 4,
    parameter int unsigned MEM_ADDR_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bemp_pkg::in_beat_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bemp_pkg::out_beat_t   m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [16:0]           cfg_wdata
);
    import bemp_pkg::*;

    localparam int unsigned MEM_DEPTH = BOARDS << MEM_ADDR_BITS;
    localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);

    logic              fire;
    logic              out_free;
    logic              mem_we, mem_re;
    logic [MEM_AW-1:0] mem_addr;
    logic [7:0]        mem_wdata, mem_rdata;
    pend_info_t        info;

    logic              pend_reg, pend_next;
    logic              m_valid_reg, m_valid_next;
    pend_info_t        info_reg;
    out_beat_t         m_data_reg;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = !pend_reg || out_free;
    assign fire      = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    bemp_ctrl #(
        .BOARDS(BOARDS),
        .MEM_ADDR_BITS(MEM_ADDR_BITS),
        .MEM_AW(MEM_AW)
    ) u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .fire(fire),
        .beat(s_data),
        .cfg_valid(cfg_valid),
        .cfg_wdata(cfg_wdata),
        .mem_we(mem_we),
        .mem_re(mem_re),
        .mem_addr(mem_addr),
        .mem_wdata(mem_wdata),
        .info(info)
    );

    bemp_mem #(
        .DEPTH(MEM_DEPTH),
        .AW(MEM_AW)
    ) u_mem (
        .aclk(aclk),
        .we(mem_we),
        .re(mem_re),
        .addr(mem_addr),
        .wdata(mem_wdata),
        .rdata(mem_rdata)
    );

    assign pend_next    = fire || (pend_reg && !out_free);
    assign m_valid_next = pend_reg || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            info_reg <= info;
        end
        if (pend_reg && out_free) begin
            m_data_reg.read_data  <= info_reg.use_mem ? mem_rdata : IDLE_BYTE;
            m_data_reg.dirty_mask <= info_reg.dirty_mask;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/bemp_checker.sv =====
// Port-level checker for banked_extended_memory_port, with its bind.
// Depends on bemp_pkg and banked_extended_memory_port_defines.svh.
`include "banked_extended_memory_port_defines.svh"

module bemp_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input bemp_pkg::out_beat_t  m_data,
    input logic                 cfg_valid,
    input logic                 cfg_ready
);
    import bemp_pkg::*;

    `BEMP_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result beat changed while stalled")
    `BEMP_ASSERT_NOW(a_result_kind, m_valid, m_data.dirty_mask == 4'd0 || m_data.read_data == IDLE_BYTE, "result mixes data byte and dirty mask")
    `BEMP_ASSERT_NOW(a_stall_cause, !s_ready, m_valid && !m_ready, "input stalled without a stalled result")
    `BEMP_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind banked_extended_memory_port bemp_checker u_bemp_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data(m_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for banked_extended_memory_port: address-lane, data-lane and
// dirty-mask traffic under random idling and stalls, checked against an in-bench predictor.
// Depends on bemp_pkg and the banked_extended_memory_port RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bemp_pkg::*;

    localparam int BOARDS        = 4;
    localparam int MEM_ADDR_BITS = 16;
    localparam int BOARD_BYTES   = 1 << MEM_ADDR_BITS;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES   = 80;
    localparam int MAX_REPORTS   = 20;
    localparam int PHASES        = 7;

    typedef struct {
        in_beat_t  beat;
        out_beat_t want;
    } port_access_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_beat_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_beat_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [16:0] cfg_wdata = '0;

    banked_extended_memory_port #(
        .BOARDS        (BOARDS),
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state
    logic [ADDR_W-1:0] board_addr [BOARDS];
    logic [7:0]        mem_image [BOARDS*BOARD_BYTES];
    bit                mem_written [BOARDS*BOARD_BYTES];
    logic [BOARDS-1:0] dirty_boards;
    logic [CAP_W-1:0]  capacity;

    port_access_t queued_accesses[$];
    out_beat_t    awaited_results[$];

    bit beat_taken;
    bit sender_steady;
    bit receiver_steady;
    int hold_requests;
    int holds_served;
    int hold_left;
    int live_items;
    int mismatches;
    int beats_checked;
    int bytes_stored;
    int bytes_fetched;
    int takes;

    function automatic int usable_bytes();
        return (capacity > BOARD_BYTES) ? BOARD_BYTES : int'(capacity);
    endfunction

    function automatic int mem_index(int board);
        return board * BOARD_BYTES + int'(board_addr[board][MEM_ADDR_BITS-1:0]);
    endfunction

    function automatic out_beat_t access_port(in_beat_t b);
        int         board;
        logic [1:0] lane;
        bit         present;
        int         idx;
        out_beat_t  r;
        board = int'(b.port_offset[7:2]);
        lane  = b.port_offset[1:0];
        r.read_data  = IDLE_BYTE;
        r.dirty_mask = '0;
        if (b.operation == OP_TAKE) begin
            r.dirty_mask = dirty_boards[3:0];
            dirty_boards = '0;
            takes++;
        end else if ((b.operation == OP_WRITE || b.operation == OP_READ) && board < BOARDS) begin
            present = board_addr[board] < usable_bytes();
            idx = mem_index(board);
            if (b.operation == OP_WRITE) begin
                case (lane)
                    LANE_ADDR_LO:  board_addr[board][7:0]   = b.write_data;
                    LANE_ADDR_MID: board_addr[board][15:8]  = b.write_data;
                    LANE_ADDR_HI:  board_addr[board][23:16] = b.write_data;
                    default: begin
                        if (present) begin
                            mem_image[idx]   = b.write_data;
                            mem_written[idx] = 1'b1;
                            bytes_stored++;
                        end
                        dirty_boards[board] = 1'b1;
                        board_addr[board] = board_addr[board] + 1'b1;
                    end
                endcase
            end else if (lane == LANE_DATA) begin
                if (present) begin
                    r.read_data = mem_image[idx];
                    bytes_fetched++;
                end
                board_addr[board] = board_addr[board] + 1'b1;
            end
        end
        return r;
    endfunction

    function automatic bit reads_unwritten(in_beat_t b);
        int board;
        board = int'(b.port_offset[7:2]);
        if (b.operation != OP_READ || b.port_offset[1:0] != LANE_DATA || board >= BOARDS)
            return 1'b0;
        if (board_addr[board] >= usable_bytes())
            return 1'b0;
        return !mem_written[mem_index(board)];
    endfunction

    function automatic in_beat_t port_beat(logic [1:0] op, int board, logic [1:0] lane,
                                           logic [7:0] data);
        in_beat_t b;
        b.operation   = op;
        b.port_offset = {board[5:0], lane};
        b.write_data  = data;
        return b;
    endfunction

    // an unwritten byte must never be read back, so such a read becomes a store
    task automatic queue_access(in_beat_t b);
        port_access_t a;
        if (reads_unwritten(b))
            b.operation = OP_WRITE;
        live_items++;
        a.beat = b;
        a.want = access_port(b);
        queued_accesses.push_back(a);
    endtask

    task automatic point_board(int board, logic [23:0] addr);
        int first;
        int lane;
        first = int'($urandom_range(0, 2));
        for (int i = 0; i < 3; i++) begin
            lane = (first + i) % 3;
            queue_access(port_beat(OP_WRITE, board, 2'(lane), addr[8*lane +: 8]));
        end
    endtask

    task automatic queue_burst();
        int          board;
        int          n;
        logic [23:0] base;
        board = ($urandom_range(0, 99) < 90) ? int'($urandom_range(0, BOARDS - 1))
                                              : int'($urandom_range(BOARDS, 63));
        case ($urandom_range(0, 4))
            0:       base = 24'($urandom_range(0, 255));
            1:       base = 24'(usable_bytes() + int'($urandom_range(0, 8)) - 4);
            2:       base = 24'(24'hFFFFFF - $urandom_range(0, 5));
            3:       base = 24'($urandom);
            default: base = 24'(BOARD_BYTES + int'($urandom_range(0, 8)) - 4);
        endcase
        n = int'($urandom_range(1, 8));
        point_board(board, base);
        repeat (n) queue_access(port_beat(OP_WRITE, board, LANE_DATA, 8'($urandom)));
        if ($urandom_range(0, 99) < 20)
            queue_access(port_beat(OP_TAKE, int'($urandom_range(0, 63)), 2'($urandom),
                                   8'($urandom)));
        if ($urandom_range(0, 99) < 80) begin
            point_board(board, base);
            repeat (n + $urandom_range(0, 2))
                queue_access(port_beat(OP_READ, board, LANE_DATA, 8'($urandom)));
        end
    endtask

    task automatic fill_phase(int target);
        int start;
        int pick;
        start = live_items;
        while (live_items - start < target) begin
            pick = int'($urandom_range(0, 99));
            if (pick < 75) begin
                queue_burst();
            end else if (pick < 85) begin
                queue_access(port_beat(OP_TAKE, int'($urandom_range(0, 63)), 2'($urandom),
                                       8'($urandom)));
            end else if (pick < 93) begin
                queue_access(port_beat(2'($urandom), int'($urandom_range(0, BOARDS - 1)),
                                       2'($urandom), 8'($urandom)));
            end else begin
                queue_access(port_beat(2'($urandom), int'($urandom_range(0, 63)),
                                       2'($urandom), 8'($urandom)));
            end
        end
    endtask

    task automatic queue_directed();
        queue_access(port_beat(OP_TAKE, 0, LANE_ADDR_LO, 8'h00));
        queue_access(port_beat(OP_WRITE, 0, LANE_ADDR_LO, 8'hFF));
        queue_access(port_beat(OP_WRITE, 0, LANE_ADDR_MID, 8'hFF));
        queue_access(port_beat(OP_WRITE, 0, LANE_ADDR_HI, 8'hFF));
        queue_access(port_beat(OP_WRITE, 0, LANE_DATA, 8'hAA));
        queue_access(port_beat(OP_WRITE, 0, LANE_DATA, 8'h00));
        queue_access(port_beat(OP_WRITE, 0, LANE_DATA, 8'hFF));
        queue_access(port_beat(OP_READ, 0, LANE_ADDR_LO, 8'h00));
        queue_access(port_beat(OP_WRITE, 0, LANE_ADDR_LO, 8'h00));
        queue_access(port_beat(OP_WRITE, 0, LANE_ADDR_MID, 8'h00));
        queue_access(port_beat(OP_WRITE, 0, LANE_ADDR_HI, 8'h00));
        queue_access(port_beat(OP_READ, 0, LANE_DATA, 8'h00));
        queue_access(port_beat(OP_READ, 0, LANE_DATA, 8'hFF));
        queue_access(port_beat(OP_WRITE, 63, LANE_DATA, 8'h55));
        queue_access(port_beat(OP_READ, 63, LANE_DATA, 8'hFF));
        queue_access(port_beat(OP_WRITE, 4, LANE_DATA, 8'h33));
        queue_access(port_beat(OP_WRITE, 3, LANE_DATA, 8'h5A));
        queue_access(port_beat(OP_UNUSED, 0, LANE_DATA, 8'hFF));
        queue_access(port_beat(OP_TAKE, 0, LANE_ADDR_LO, 8'h00));
        queue_access(port_beat(OP_TAKE, 63, LANE_DATA, 8'hFF));
    endtask

    task automatic drain();
        while (queued_accesses.size() != 0 || awaited_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [16:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        capacity = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at result beat %0d: %s got %0h, want %0h",
                     beats_checked, what, got, want);
    endtask

    // sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || beat_taken) begin
            beat_taken = 1'b0;
            if (queued_accesses.size() != 0 && (sender_steady || $urandom_range(0, 99) >= 30)) begin
                s_valid <= 1'b1;
                s_data  <= queued_accesses[0].beat;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            awaited_results.push_back(queued_accesses[0].want);
            queued_accesses.pop_front();
            beat_taken = 1'b1;
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= receiver_steady || ($urandom_range(0, 99) >= 30);
        end
    end

    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_checked++;
            if (awaited_results.size() == 0) begin
                report_mismatch("result beat with nothing awaited", 32'(m_data), 32'd0);
            end else begin
                want = awaited_results.pop_front();
                if (m_data.read_data !== want.read_data)
                    report_mismatch("read_data", 32'(m_data.read_data),
                                    32'(want.read_data));
                if (m_data.dirty_mask !== want.dirty_mask)
                    report_mismatch("dirty_mask", 32'(m_data.dirty_mask),
                                    32'(want.dirty_mask));
            end
        end
    end

    initial begin
        logic [16:0] cap;
        for (int i = 0; i < BOARDS; i++)
            board_addr[i] = '0;
        dirty_boards = '0;
        capacity = CAP_RESET;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        queue_directed();
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       cap = 17'd65536;
                1:       cap = 17'd0;
                2:       cap = 17'h1FFFF;
                3:       cap = 17'd300;
                4:       cap = 17'd65537;
                5:       cap = 17'($urandom_range(1, 65535));
                default: cap = 17'd65535;
            endcase
            write_capacity(cap);
            sender_steady   = (phase == 2 || phase == 3);
            receiver_steady = (phase == 2);
            if (phase == 3)
                hold_requests++;
            fill_phase((phase == 1 || phase == 6) ? 150 : 280);
            drain();
        end

        $display("%0d result beats checked over %0d capacity settings, zero and oversized included",
                 beats_checked, PHASES);
        $display("%0d bytes stored, %0d read back, %0d dirty-mask takes",
                 bytes_stored, bytes_fetched, takes);
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("testbench failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/bemp_pkg.sv
src/bemp_mem.sv
src/bemp_ctrl.sv
src/banked_extended_memory_port.sv
src/bemp_checker.sv
dv/testbench.sv
